/* src/rmd128_pkg.sv */
package rmd128_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] byte_value;
    } rmd128_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD2,
        ST_OUT
    } rmd128_state_t;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;

    function automatic logic [3:0] left_word(input logic [5:0] j);
        logic [3:0] w [64];
        w = '{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
              7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
              3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
              1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2};
        return w[j];
    endfunction

    function automatic logic [3:0] right_word(input logic [5:0] j);
        logic [3:0] w [64];
        w = '{5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
              6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
              15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
              8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14};
        return w[j];
    endfunction

    function automatic logic [4:0] left_rot(input logic [5:0] j);
        logic [4:0] r [64];
        r = '{11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
              7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
              11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
              11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12};
        return r[j];
    endfunction

    function automatic logic [4:0] right_rot(input logic [5:0] j);
        logic [4:0] r [64];
        r = '{8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
              9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
              9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
              15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8};
        return r[j];
    endfunction

    function automatic logic [31:0] left_k(input logic [1:0] r);
        unique case (r)
            2'd0: return 32'h00000000;
            2'd1: return 32'h5a827999;
            2'd2: return 32'h6ed9eba1;
            default: return 32'h8f1bbcdc;
        endcase
    endfunction

    function automatic logic [31:0] right_k(input logic [1:0] r);
        unique case (r)
            2'd0: return 32'h50a28be6;
            2'd1: return 32'h5c4dd124;
            2'd2: return 32'h6d703ef3;
            default: return 32'h00000000;
        endcase
    endfunction

    function automatic logic [31:0] boolfn(input logic [1:0] sel, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
        unique case (sel)
            2'd0: return x ^ y ^ z;
            2'd1: return (x & y) | (~x & z);
            2'd2: return (x | ~y) ^ z;
            default: return (x & z) | (y & ~z);
        endcase
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] d;
        d = {v, v} << s;
        return d[63:32];
    endfunction

endpackage

/* src/rmd128_front.sv */
module rmd128_front
    import rmd128_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         valid,
    output logic         ready,
    input  logic         cmd,
    input  logic [7:0]   byte_value,
    output logic         q_valid,
    input  logic         q_ready,
    output rmd128_item_t q_item
);

    rmd128_item_t mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         push, pop;

    assign ready   = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rp_reg];
    assign push    = valid && ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= '{cmd: cmd, byte_value: byte_value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* src/rmd128_back.sv */
module rmd128_back
    import rmd128_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    output logic         q_ready,
    input  rmd128_item_t q_item,
    output logic         valid,
    input  logic         ready,
    output logic [63:0]  digest_low,
    output logic [63:0]  digest_high
);

    rmd128_state_t state_reg, state_next;
    logic [31:0]   blk_reg [16];
    logic [31:0]   cv_reg [4];
    logic [31:0]   la_reg, lb_reg, lc_reg, ld_reg, ra_reg, rb_reg, rc_reg, rd_reg;
    logic [5:0]    pos_reg, j_reg;
    logic [63:0]   bits_reg;
    logic          fin_reg, out_valid_reg;
    logic [63:0]   dlo_reg, dhi_reg;
    logic [31:0]   tl, tr;
    logic [1:0]    rnd;
    logic          take;

    assign rnd = j_reg[5:4];
    assign tl = rotl(la_reg + boolfn(rnd, lb_reg, lc_reg, ld_reg) + blk_reg[left_word(j_reg)]
                     + left_k(rnd), left_rot(j_reg));
    assign tr = rotl(ra_reg + boolfn(~rnd, rb_reg, rc_reg, rd_reg) + blk_reg[right_word(j_reg)]
                     + right_k(rnd), right_rot(j_reg));

    assign take        = (state_reg == ST_IDLE) && q_valid;
    assign q_ready     = (state_reg == ST_IDLE);
    assign valid       = out_valid_reg;
    assign digest_low  = dlo_reg;
    assign digest_high = dhi_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && (q_item.cmd || pos_reg == 6'd63))
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (j_reg == 6'd63)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (pos_reg == 6'd0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD2;
                end
            end
            ST_PAD2:
            begin
                state_next = ST_ROUND;
            end
            ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            j_reg         <= '0;
            bits_reg      <= '0;
            fin_reg       <= 1'b0;
            cv_reg        <= '{IV0, IV1, IV2, IV3};
            blk_reg       <= '{default: 32'h0};
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        la_reg <= cv_reg[0]; lb_reg <= cv_reg[1];
                        lc_reg <= cv_reg[2]; ld_reg <= cv_reg[3];
                        ra_reg <= cv_reg[0]; rb_reg <= cv_reg[1];
                        rc_reg <= cv_reg[2]; rd_reg <= cv_reg[3];
                        j_reg  <= '0;
                        blk_reg[pos_reg[5:2]] <= blk_reg[pos_reg[5:2]]
                            | ({24'h0, (q_item.cmd ? 8'h80 : q_item.byte_value)}
                               << {pos_reg[1:0], 3'b000});
                        if (q_item.cmd)
                        begin
                            fin_reg <= 1'b1;
                            if (pos_reg <= 6'd55)
                            begin
                                blk_reg[14] <= bits_reg[31:0];
                                blk_reg[15] <= bits_reg[63:32];
                                pos_reg     <= '0;
                            end
                        end
                        else
                        begin
                            bits_reg <= bits_reg + 64'd8;
                            pos_reg  <= pos_reg + 6'd1;
                        end
                    end
                end
                ST_ROUND:
                begin
                    la_reg <= ld_reg; ld_reg <= lc_reg; lc_reg <= lb_reg; lb_reg <= tl;
                    ra_reg <= rd_reg; rd_reg <= rc_reg; rc_reg <= rb_reg; rb_reg <= tr;
                    j_reg  <= j_reg + 6'd1;
                end
                ST_FINAL:
                begin
                    cv_reg[0] <= cv_reg[1] + lc_reg + rd_reg;
                    cv_reg[1] <= cv_reg[2] + ld_reg + ra_reg;
                    cv_reg[2] <= cv_reg[3] + la_reg + rb_reg;
                    cv_reg[3] <= cv_reg[0] + lb_reg + rc_reg;
                    blk_reg   <= '{default: 32'h0};
                end
                ST_PAD2:
                begin
                    la_reg <= cv_reg[0]; lb_reg <= cv_reg[1];
                    lc_reg <= cv_reg[2]; ld_reg <= cv_reg[3];
                    ra_reg <= cv_reg[0]; rb_reg <= cv_reg[1];
                    rc_reg <= cv_reg[2]; rd_reg <= cv_reg[3];
                    j_reg  <= '0;
                    blk_reg[14] <= bits_reg[31:0];
                    blk_reg[15] <= bits_reg[63:32];
                    pos_reg     <= '0;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        dlo_reg       <= {cv_reg[1], cv_reg[0]};
                        dhi_reg       <= {cv_reg[3], cv_reg[2]};
                        out_valid_reg <= 1'b1;
                        cv_reg        <= '{IV0, IV1, IV2, IV3};
                        bits_reg      <= '0;
                        fin_reg       <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* src/ripemd128_hash_engine_core.sv */
// RIPEMD-128 byte-stream hash engine.
// Input channel (valid/ready): cmd=0 absorbs byte_value, cmd=1 pads the
// message, finishes it and yields one digest item.
// Output channel (valid/ready): digest_low holds digest bytes 0..7 and
// digest_high bytes 8..15, byte i in bits 8i+7..8i.
// A two-entry queue sits in front of the compression sequencer, so input
// items are taken while the sequencer is busy until the queue fills.
// A plain byte is absorbed from the idle state; the 64th byte of a block
// runs the 64 rounds of the shared round unit and then a feed-forward step.
// A finish runs one block, or two when more than 55 bytes are pending
// and a second padding block is needed; the digest is then registered in the output state.
// While the receiver stalls, the digest register holds its value and the
// sequencer keeps absorbing bytes of the next message; a further finish
// waits until the held digest is taken, and meanwhile the queue fills.
// Reset loads the standard initial chaining value, clears the block,
// byte position and bit count and empties the queue; after every digest
// the engine returns to that state for the next message.
module ripemd128_hash_engine_core
    import rmd128_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_low,
    output logic [63:0] digest_high
);

    logic         q_valid, q_ready;
    rmd128_item_t q_item;

    rmd128_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (in_valid),
        .ready      (in_ready),
        .cmd        (cmd),
        .byte_value (byte_value),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    rmd128_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .valid       (out_valid),
        .ready       (out_ready),
        .digest_low  (digest_low),
        .digest_high (digest_high)
    );

endmodule

/* verif/ripemd128_hash_engine_core_tb.sv */
`timescale 1ns / 100ps

module ripemd128_hash_engine_core_tb;
    import rmd128_pkg::*;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
    } digest_t;

    localparam int LIMIT_CYCLES = 1500000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [7:0]  byte_value;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    rmd128_item_t pending_items[$];
    digest_t      expected_digests[$];

    logic [31:0] hash_cv[4];
    logic [31:0] msg_words[16];
    int unsigned msg_pos;
    logic [63:0] msg_bits;

    int  errors;
    int  cycle_count;
    bit  quiet_mode;
    bit  hold_off_req;
    int  in_gap;
    int  out_gap;
    int  hold_left;

    // accepted at the last rising edge
    logic in_ready_seen;

    ripemd128_hash_engine_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digest_low (digest_low),
        .digest_high(digest_high)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [31:0] mix_fn(input int sel, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
        case (sel)
            0: mix_fn = x ^ y ^ z;
            1: mix_fn = (x & y) | (~x & z);
            2: mix_fn = (x | ~y) ^ z;
            default: mix_fn = (x & z) | (y & ~z);
        endcase
    endfunction

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int s);
        rot_left = (s == 0) ? v : ((v << s) | (v >> (32 - s)));
    endfunction

    task automatic compress_block();
        int lw[64] = '{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
                       7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
                       3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
                       1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2};
        int ls[64] = '{11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
                       7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
                       11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
                       11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12};
        int rw[64] = '{5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
                       6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
                       15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
                       8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14};
        int rs[64] = '{8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
                       9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
                       9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
                       15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8};
        logic [31:0] kl[4] = '{32'h0, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc};
        logic [31:0] kr[4] = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h0};
        logic [31:0] la, lb, lc, ld, ra, rb, rc, rd, t;
        logic [31:0] n0, n1, n2, n3;
        int r;
        la = hash_cv[0]; lb = hash_cv[1]; lc = hash_cv[2]; ld = hash_cv[3];
        ra = la; rb = lb; rc = lc; rd = ld;
        for (int j = 0; j < 64; j++)
        begin
            r = j / 16;
            t = rot_left(la + mix_fn(r, lb, lc, ld) + msg_words[lw[j]] + kl[r], ls[j]);
            la = ld; ld = lc; lc = lb; lb = t;
            t = rot_left(ra + mix_fn(3 - r, rb, rc, rd) + msg_words[rw[j]] + kr[r], rs[j]);
            ra = rd; rd = rc; rc = rb; rb = t;
        end
        n0 = hash_cv[1] + lc + rd;
        n1 = hash_cv[2] + ld + ra;
        n2 = hash_cv[3] + la + rb;
        n3 = hash_cv[0] + lb + rc;
        hash_cv = '{n0, n1, n2, n3};
        msg_pos = 0;
        foreach (msg_words[i]) msg_words[i] = '0;
    endtask

    task automatic restart_message();
        hash_cv = '{IV0, IV1, IV2, IV3};
        foreach (msg_words[i]) msg_words[i] = '0;
        msg_pos = 0;
        msg_bits = '0;
    endtask

    task automatic insert_byte(input logic [7:0] b);
        msg_words[msg_pos / 4] |= 32'(b) << (8 * (msg_pos % 4));
    endtask

    task automatic predict_item(input rmd128_item_t it);
        digest_t d;
        int p;
        p = msg_pos;
        if (!it.cmd)
        begin
            insert_byte(it.byte_value);
            msg_bits += 64'd8;
            msg_pos = (p + 1) % 64;
            if (p == 63)
                compress_block();
        end
        else
        begin
            insert_byte(8'h80);
            if (p > 55)
                compress_block();
            msg_words[14] = msg_bits[31:0];
            msg_words[15] = msg_bits[63:32];
            compress_block();
            d.lo = {hash_cv[1], hash_cv[0]};
            d.hi = {hash_cv[3], hash_cv[2]};
            expected_digests.push_back(d);
            restart_message();
        end
    endtask

    task automatic add_msg(input int len);
        rmd128_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.cmd = 1'b0;
            it.byte_value = 8'($urandom);
            pending_items.push_back(it);
        end
        it.cmd = 1'b1;
        it.byte_value = 8'($urandom);
        pending_items.push_back(it);
    endtask

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            cmd        <= 1'b0;
            byte_value <= 8'h00;
            in_gap     <= 0;
        end
        else if (!in_valid || in_ready_seen)
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (pending_items.size() > 0)
            begin
                rmd128_item_t it;
                it = pending_items.pop_front();
                predict_item(it);
                in_valid   <= 1'b1;
                cmd        <= it.cmd;
                byte_value <= it.byte_value;
                if (!quiet_mode && $urandom_range(0, 19) == 0)
                    in_gap <= $urandom_range(1, 16);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ready_seen <= 1'b0;
        else
            in_ready_seen <= in_valid && in_ready;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
            hold_left <= 0;
        end
        else if (hold_off_req && hold_left == 0)
        begin
            out_ready <= 1'b0;
            hold_left <= 3000;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (out_gap > 0)
        begin
            out_ready <= 1'b0;
            out_gap   <= out_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!quiet_mode && $urandom_range(0, 9) == 0)
                out_gap <= $urandom_range(1, 16);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_digests.size() == 0)
            begin
                $display("%0t: unexpected digest lo=%h hi=%h", $time, digest_low, digest_high);
                errors++;
            end
            else
            begin
                digest_t e;
                e = expected_digests.pop_front();
                if (digest_low !== e.lo)
                begin
                    $display("%0t: digest_low expected %h actual %h", $time, e.lo, digest_low);
                    errors++;
                end
                if (digest_high !== e.hi)
                begin
                    $display("%0t: digest_high expected %h actual %h", $time, e.hi, digest_high);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("ripemd128_hash_engine_core_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int n;
        rmd128_item_t it;
        errors = 0;
        cycle_count = 0;
        quiet_mode = 0;
        hold_off_req = 0;
        restart_message();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_msg(0);
        add_msg(1);
        it.cmd = 1'b0; it.byte_value = 8'h00; pending_items.push_back(it);
        it.byte_value = 8'hff; pending_items.push_back(it);
        it.cmd = 1'b1; it.byte_value = 8'h5a; pending_items.push_back(it);
        add_msg(3);
        add_msg(13);

        // hold off the receiver while many finishes queue up
        hold_off_req = 1;
        for (int i = 0; i < 8; i++) add_msg(0);
        wait (hold_left > 0);
        hold_off_req = 0;

        n = 0;
        while (n < 1200)
        begin
            int len;
            case ($urandom_range(0, 5))
                0: len = $urandom_range(55, 57);
                1: len = $urandom_range(62, 66);
                2: len = $urandom_range(118, 122);
                default: len = $urandom_range(0, 40);
            endcase
            add_msg(len);
            n += len + 1;
        end
        wait (pending_items.size() < 200);
        quiet_mode = 1;
        for (int i = 0; i < 6; i++) add_msg($urandom_range(0, 70));

        wait (pending_items.size() == 0);
        wait (in_valid == 1'b0 || in_ready_seen);
        @(posedge clk);
        while (in_valid) @(posedge clk);
        wait (expected_digests.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("ripemd128_hash_engine_core_tb: PASS");
        else
            $display("ripemd128_hash_engine_core_tb: FAIL");
        $finish;
    end

endmodule
